/* rtl/mmcn_pkg.sv */
`timescale 1ns / 1ps
// Package for the min-max column normaliser: widths, defaults, sequencer states
// and the status struct of the shared divider. No dependencies.
package mmcn_pkg;

  localparam int MAX_ROWS_DEF = 64;   // default store depth
  localparam int SAMPLE_W     = 32;   // Q16.16 sample
  localparam int TAG_W        = 6;    // column identifier
  localparam int ROW_W        = 6;    // row index on the result
  localparam int Q_W          = 17;   // unsigned Q1.16 quotient
  localparam int FRAC_W       = 16;   // fraction bits of the quotient

  // Fixed-point 0.0 in the result format.
  localparam logic [Q_W-1:0] SCALED_ZERO = '0;
  // Fixed-point 1.0 in the result format, the upper bound of every result.
  localparam logic [Q_W-1:0] SCALED_ONE  = Q_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,   // take samples
    S_READ,   // address the store
    S_LOAD,   // form sample - min, start the divider
    S_DIV,    // wait for the quotient
    S_OUT     // present one result item
  } mmcn_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mmcn_div_stat_t;

endpackage

/* rtl/mmcn_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmcn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mmcn_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider: floor(num * 2^16 / den) for num <= den, one
// quotient bit per cycle. Depends on mmcn_pkg.
module mmcn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mmcn_pkg::SAMPLE_W-1:0] num,
  input  logic [mmcn_pkg::SAMPLE_W-1:0] den,
  output logic [mmcn_pkg::Q_W-1:0]      quo,
  output mmcn_pkg::mmcn_div_stat_t      stat
);
  import mmcn_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W:0]   rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]      quo_r, quo_nxt;
  logic                ge;
  logic [SAMPLE_W:0]   diff;

  // remainder stays below the divisor, so the doubled value fits one extra bit
  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = {diff[SAMPLE_W-1:0], 1'b0};
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/min_max_column_normalizer_top.sv */
`timescale 1ns / 1ps
// Min-max column normaliser, top level. Depends on mmcn_pkg, mmcn_ram and
// mmcn_div.
//
// Usage:
//   Input channel (in_valid / in_stall): one signed Q16.16 sample per item,
//   with its column id and a last mark. A sample item is taken in a single
//   cycle while the block is idle; samples are stored and the running min and
//   max kept. Once MAX_ROWS samples are held, further samples are dropped and
//   the overflow flag set for the run.
//   On the item marked last the block replays every stored sample in load
//   order and holds in_stall high until the whole replay has been delivered.
//   Result channel (out_valid / out_stall): one item per stored sample,
//   (sample - min) / (max - min) as unsigned Q1.16, truncated, with min, max,
//   column tag, overflow flag and a mark on the final row. A zero range gives
//   0 on every row.
//   Each result item is worked out in turn: the sequencer reads the store,
//   forms sample - min and starts the shared radix-2 divider, waits for its
//   quotient bits and its done flag, then presents the item; the next row is
//   read only once the item has been taken.
//   A stalled result item holds its value and freezes the replay until taken.
//   After the final row the run state clears and samples are taken again.
//   Reset (synchronous, active low) empties the run; the store needs no
//   clearing pass, as only rows written in the current run are read.
module min_max_column_normalizer_top #(
  parameter int MAX_ROWS = mmcn_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mmcn_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [mmcn_pkg::TAG_W-1:0]           in_column_id,
  input  logic                                 in_is_last,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mmcn_pkg::Q_W-1:0]             out_scaled,
  output logic [mmcn_pkg::ROW_W-1:0]           out_row_index,
  output logic signed [mmcn_pkg::SAMPLE_W-1:0] out_col_min,
  output logic signed [mmcn_pkg::SAMPLE_W-1:0] out_col_max,
  output logic [mmcn_pkg::TAG_W-1:0]           out_column_tag,
  output logic                                 out_overflow,
  output logic                                 out_final_row
);
  import mmcn_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);       // store address
  localparam int CW = $clog2(MAX_ROWS + 1);   // fill count, holds MAX_ROWS itself

  mmcn_state_t state_r, state_nxt;

  logic [CW-1:0]              count_r;
  logic [AW-1:0]              idx_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic                       ovf_r;
  logic [TAG_W-1:0]           tag_r;
  logic [Q_W-1:0]             scaled_r;
  logic                       final_r;

  logic                       in_acc;
  logic                       out_acc;
  logic                       full;
  logic                       store_we;
  logic                       last_row;
  logic                       div_start;
  logic                       zero_range;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [SAMPLE_W-1:0]        range_w;
  logic [SAMPLE_W-1:0]        offset_w;
  logic [Q_W-1:0]             quo;
  mmcn_div_stat_t             div_stat;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign full     = count_r == CW'(MAX_ROWS);
  assign store_we = in_acc && !full;
  assign last_row = idx_r == AW'(count_r - CW'(1));

  // both differences are non-negative and below 2^32, so the low bits suffice
  assign range_w    = SAMPLE_W'(max_r - min_r);
  assign offset_w   = SAMPLE_W'($signed(rd_data) - min_r);
  assign zero_range = max_r == min_r;

  mmcn_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  mmcn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (offset_w),
    .den   (range_w),
    .quo   (quo),
    .stat  (div_stat)
  );

  // Next state of the replay sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_is_last) state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_nxt = last_row ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE:  in_stall  = 1'b0;
      S_LOAD:  div_start = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // Run state: fill count, running extremes, overflow and replay index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (full) begin
          // drop the sample, flag the run
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
          if (count_r == '0) begin
            min_r <= in_sample;
            max_r <= in_sample;
          end else begin
            if (in_sample < min_r) min_r <= in_sample;
            if (in_sample > max_r) max_r <= in_sample;
          end
        end
        if (in_is_last) idx_r <= '0;
      end
      if (out_acc) begin
        if (last_row) begin
          // end of run: clear for the next column
          count_r <= '0;
          idx_r   <= '0;
          min_r   <= '0;
          max_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
    end
  end

  // Result payload and captured tag.
  always_ff @(posedge clk) begin
    if (in_acc && in_is_last) begin
      tag_r <= in_column_id;
    end
    if (state_r == S_DIV && div_stat.done) begin
      scaled_r <= zero_range ? SCALED_ZERO : quo;
      final_r  <= last_row;
    end
  end

  assign out_scaled     = scaled_r;
  assign out_row_index  = ROW_W'(idx_r);
  assign out_col_min    = min_r;
  assign out_col_max    = max_r;
  assign out_column_tag = tag_r;
  assign out_overflow   = ovf_r;
  assign out_final_row  = final_r;

endmodule

/* rtl/mmcn_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the min-max column normaliser and its bind to the
// top level. Depends on mmcn_pkg.
module mmcn_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [mmcn_pkg::Q_W-1:0]             out_scaled,
  input logic signed [mmcn_pkg::SAMPLE_W-1:0] out_col_min,
  input logic signed [mmcn_pkg::SAMPLE_W-1:0] out_col_max,
  input logic                                 out_final_row
);
  import mmcn_pkg::*;

  // no sample is taken while a replay is in flight
  a_stall_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during replay");

  // a held result item keeps its value
  a_hold_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scaled))
    else $error("stalled result changed");

  // every result lies in [0, 1.0]
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scaled <= SCALED_ONE)
    else $error("scaled value above 1.0");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_col_min <= out_col_max)
    else $error("column min above max");

  // handing over the final row returns the block to taking samples
  a_final_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_final_row |=> !out_valid && !in_stall)
    else $error("block not idle after final row");

endmodule

bind min_max_column_normalizer_top mmcn_checker u_mmcn_checker (.*);

/* verif/min_max_column_normalizer_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for min_max_column_normalizer_top: sends columns of Q16.16 samples,
// predicts every replayed row in a small scoreboard class and checks each result item.
// Depends on mmcn_pkg and the normaliser RTL only.
module min_max_column_normalizer_top_test;
  import mmcn_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_TARGET  = 470;
  localparam int QUIET_FROM   = 400;      // idling stops once this many items are in
  localparam int TAIL_CYCLES  = 100;
  // Slowest legal run: every sample replayed behind a longest result stall burst,
  // every item behind a longest idle gap; this is several times that.
  localparam int CYCLE_LIMIT  = 200000;

  // How the samples of one random column are spread.
  typedef enum int {
    SPREAD_FULL,    // any 32-bit value
    SPREAD_NARROW,  // up to 4000 LSBs above a base
    FEW_LEVELS,     // a handful of integer steps, many repeats
    EXTREMES,       // mostly signed min and max, zero and -1
    FLAT            // one value throughout, zero range
  } spread_t;

  // One expected or observed result item.
  typedef struct packed {
    logic [Q_W-1:0]             scaled;
    logic [ROW_W-1:0]           row_index;
    logic signed [SAMPLE_W-1:0] col_min;
    logic signed [SAMPLE_W-1:0] col_max;
    logic [TAG_W-1:0]           column_tag;
    logic                       overflow;
    logic                       final_row;
  } norm_row_t;

  // Column scoreboard: mirrors the store, the running min/max and the overflow flag,
  // and queues the rows a last-marked item releases.
  class column_scoreboard;
    logic signed [SAMPLE_W-1:0] held_samples[MAX_ROWS_DEF];
    int unsigned                held;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    bit                         dropped;
    norm_row_t                  rows_due[$];
    int                         errors;

    function new();
      held    = 0;
      lo      = '0;
      hi      = '0;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    // Note one accepted input item; on the last one, queue the replayed column.
    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic [TAG_W-1:0] tag,
                              logic last);
      longint unsigned span;
      longint unsigned offset;
      longint unsigned quot;
      norm_row_t       r;
      if (held < MAX_ROWS_DEF) begin
        if (held == 0) begin
          lo = s;
          hi = s;
        end else begin
          if (s < lo) lo = s;
          if (s > hi) hi = s;
        end
        held_samples[held] = s;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      span = longint'(hi) - longint'(lo);
      for (int i = 0; i < held; i++) begin
        if (span == 0) begin
          quot = 0;
        end else begin
          offset = longint'(held_samples[i]) - longint'(lo);
          quot   = (offset << FRAC_W) / span;
          if (quot > longint'(SCALED_ONE)) quot = longint'(SCALED_ONE);
        end
        r.scaled     = quot[Q_W-1:0];
        r.row_index  = ROW_W'(i);
        r.col_min    = lo;
        r.col_max    = hi;
        r.column_tag = tag;
        r.overflow   = dropped;
        r.final_row  = (i == held - 1);
        rows_due.push_back(r);
      end
      held    = 0;
      lo      = '0;
      hi      = '0;
      dropped = 1'b0;
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task compare_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    // Check one accepted result item against the oldest queued row.
    task check_row(norm_row_t got);
      norm_row_t want;
      if (rows_due.size() == 0) begin
        report_mismatch("unexpected result item, row", got.row_index, 0);
      end else begin
        want = rows_due.pop_front();
        compare_field("scaled",     got.scaled,     want.scaled);
        compare_field("row_index",  got.row_index,  want.row_index);
        compare_field("col_min",    got.col_min,    want.col_min);
        compare_field("col_max",    got.col_max,    want.col_max);
        compare_field("column_tag", got.column_tag, want.column_tag);
        compare_field("overflow",   got.overflow,   want.overflow);
        compare_field("final_row",  got.final_row,  want.final_row);
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [TAG_W-1:0]           in_column_id = '0;
  logic                       in_is_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [Q_W-1:0]             out_scaled;
  logic [ROW_W-1:0]           out_row_index;
  logic signed [SAMPLE_W-1:0] out_col_min;
  logic signed [SAMPLE_W-1:0] out_col_max;
  logic [TAG_W-1:0]           out_column_tag;
  logic                       out_overflow;
  logic                       out_final_row;

  column_scoreboard sb = new();
  bit               idling_on = 1'b1;
  int               items_sent = 0;
  int               cycle_count = 0;
  int               stall_left = 0;
  int               quiet_left = 0;
  norm_row_t        seen_row;

  min_max_column_normalizer_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_column_id  (in_column_id),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scaled    (out_scaled),
    .out_row_index (out_row_index),
    .out_col_min   (out_col_min),
    .out_col_max   (out_col_max),
    .out_column_tag(out_column_tag),
    .out_overflow  (out_overflow),
    .out_final_row (out_final_row)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Abort a hung run: a missing row or a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result-side back-pressure: random stall bursts, broken up by quiet
  // stretches so the replay also runs flat out. Change only on the falling edge.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (quiet_left != 0) begin
      quiet_left <= quiet_left - 1;
      out_stall  <= 1'b0;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      if ($urandom_range(0, 7) == 0) quiet_left <= $urandom_range(10, 60);
      out_stall <= 1'b0;
    end
  end

  // Check every result item taken at a rising edge. Values read here are the ones
  // held before the edge, so the handshake is judged on settled signals.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_row.scaled     = out_scaled;
      seen_row.row_index  = out_row_index;
      seen_row.col_min    = out_col_min;
      seen_row.col_max    = out_col_max;
      seen_row.column_tag = out_column_tag;
      seen_row.overflow   = out_overflow;
      seen_row.final_row  = out_final_row;
      sb.check_row(seen_row);
    end
  end

  // Present one input item from a falling edge and hold it until taken. An optional
  // idle gap comes first; valid stays high across back-to-back items.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s,
                           input logic [TAG_W-1:0] col, input logic last);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_column_id <= col;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s, col, last);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(spread_t spread,
                                                             logic [SAMPLE_W-1:0] base);
    logic [SAMPLE_W-1:0] v;
    case (spread)
      SPREAD_NARROW: v = base + $urandom_range(0, 4000);
      FEW_LEVELS:    v = base + ($urandom_range(0, 3) << FRAC_W);
      EXTREMES: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
      end
      FLAT:          v = base;
      default:       v = $urandom;
    endcase
    return v;
  endfunction

  // Send one column; tags on the earlier items are noise, only the last one counts.
  task automatic send_column(input int len, input spread_t spread);
    logic [SAMPLE_W-1:0] base;
    logic [TAG_W-1:0]    tag;
    base = $urandom;
    tag  = $urandom_range(0, 63);
    for (int i = 0; i < len; i++) begin
      send_item(pick_sample(spread, base), (i == len - 1) ? tag : TAG_W'($urandom),
                i == len - 1);
    end
  endtask

  initial begin
    int      len;
    spread_t spread;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lone sample: zero range, the only row is also the final row.
    send_item(32'sh7FFF_FFFF, 6'd63, 1'b1);
    // Full signed span, both corners, with zero and +/-1 LSB in between.
    send_item(32'sh8000_0000, 6'd5, 1'b0);
    send_item(32'sh7FFF_FFFF, 6'd17, 1'b0);
    send_item(32'sh0000_0000, 6'd33, 1'b0);
    send_item(32'sh0000_0001, 6'd2, 1'b0);
    send_item(-32'sd1, 6'd0, 1'b1);
    // Flat column: every row must come back as 0.0.
    send_item(32'sd5, 6'd9, 1'b0);
    send_item(32'sd5, 6'd44, 1'b0);
    send_item(32'sd5, 6'd21, 1'b1);
    // Mixed signs, the min set after the first item.
    send_item(32'sd100, 6'd1, 1'b0);
    send_item(-32'sd100, 6'd62, 1'b0);
    send_item(32'sd0, 6'd42, 1'b1);
    // Alternating bit patterns on sample and tag.
    send_item(32'shAAAA_AAAA, 6'h15, 1'b0);
    send_item(32'sh5555_5555, 6'h2A, 1'b0);
    send_item(32'shFFFF_0000, 6'h2A, 1'b1);

    // Random columns: mostly short, some that fill the store exactly or overrun it,
    // including a dropped item that still carries the last mark.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) idling_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(63, 70);
        1:       len = 1;
        default: len = $urandom_range(2, 24);
      endcase
      spread = spread_t'($urandom_range(0, 4));
      send_column(len, spread);
    end
    idling_on = 1'b0;
    in_valid <= 1'b0;

    // Drain every queued row, then give the block time to show any stray item.
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mmcn_pkg.sv
rtl/mmcn_ram.sv
rtl/mmcn_div.sv
rtl/min_max_column_normalizer_top.sv
rtl/mmcn_checker.sv
verif/min_max_column_normalizer_top_test.sv
